// ===== hdl/assert_macros.svh =====
// assertion macros shared by the walker rtl
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold on every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/ptw_pkg.sv =====
// types, constants and helpers for the page table walker
// used by the channel interfaces, controller, datapath and top level
package ptw_pkg;

  localparam int VA_W      = 64;
  localparam int PA_W      = 52;
  localparam int FLAG_W    = 12;
  localparam int ENTRY_W   = 64;
  localparam int SLOT_W    = 9;
  localparam int SLOTS     = 512;
  localparam int PAGE_SHIFT = 12;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int SHIFT_L0 = 39;
  localparam int SHIFT_L1 = 30;
  localparam int SHIFT_L2 = 21;
  localparam int SHIFT_L3 = 12;

  localparam logic [1:0] LAST_UPPER = 2'd2;
  localparam logic [1:0] LEAF_LEVEL = 2'd3;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_MAP    = 1'b1;

  localparam logic [PA_W-1:0]   FRAME_MASK_RST  = 52'hFFFFFFFFFF000;
  localparam logic [FLAG_W-1:0] ENTRY_FLAGS_RST = 12'h007;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_BASE  = 2'd0,
    CFG_FRAME_MASK  = 2'd1,
    CFG_ENTRY_FLAGS = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_HIT  = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2,
    RES_DONE = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic       load_req;
    logic       rd;
    logic       take;
    logic       alloc;
    logic       sweep_we;
    logic       clr_we;
    logic       leaf_we;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       res_load;
    logic [1:0] level;
    res_sel_t   res_sel;
  } ptw_cmd_t;

  typedef struct packed {
    logic follow_ok;
    logic room_ok;
    logic dirty_fresh;
    logic sweep_last;
    logic clr_last;
    logic is_map;
  } ptw_sts_t;

  // table index bits of the virtual address for one level
  function automatic logic [SLOT_W-1:0] slot_of(logic [VA_W-1:0] va, logic [1:0] level);
    logic [SLOT_W-1:0] s;
    case (level)
      2'd0:    s = va[SHIFT_L0 +: SLOT_W];
      2'd1:    s = va[SHIFT_L1 +: SLOT_W];
      2'd2:    s = va[SHIFT_L2 +: SLOT_W];
      default: s = va[SHIFT_L3 +: SLOT_W];
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/ptw_if.sv =====
// valid/ready channel interfaces: request, result and register write
// depends on ptw_pkg for field widths
interface ptw_req_if import ptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [VA_W-1:0]   virtual_address;
  logic [PA_W-1:0]   physical_address;
  logic [FLAG_W-1:0] page_flags;

  modport source (output valid, kind, virtual_address, physical_address, page_flags,
                  input ready);
  modport sink   (input valid, kind, virtual_address, physical_address, page_flags,
                  output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VA_W-1:0]     result_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

interface ptw_cfg_if import ptw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ptw_ctrl.sv =====
// walk sequencer: clearing pass, level walk, allocation and result hand-off
// depends on ptw_pkg command/status structs
module ptw_ctrl import ptw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ptw_cmd_t cmd,
  input  ptw_sts_t sts
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_EV    = 9'b000001000,
    S_CHECK = 9'b000010000,
    S_SWEEP = 9'b000100000,
    S_ALLOC = 9'b001000000,
    S_LEAF  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] level, level_next;
  res_sel_t   res_sel, res_sel_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      level     <= 2'd0;
      res_sel   <= RES_DONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      level     <= level_next;
      res_sel   <= res_sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    level_next   = level;
    res_sel_next = res_sel;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.level    = level;
    cmd.res_sel  = res_sel;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          level_next   = 2'd0;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        if (level == LEAF_LEVEL) begin
          res_sel_next = RES_HIT;
          state_next   = S_FIN;
        end else if (sts.follow_ok) begin
          cmd.take   = 1'b1;
          level_next = level + 2'd1;
          // a map with all upper levels present goes straight to the leaf
          if (sts.is_map && level == LAST_UPPER) state_next = S_CHECK;
          else state_next = S_RD;
        end else if (sts.is_map) begin
          state_next = S_CHECK;
        end else begin
          res_sel_next = RES_MISS;
          state_next   = S_FIN;
        end
      end
      S_CHECK: begin
        if (!sts.room_ok) begin
          res_sel_next = RES_FULL;
          state_next   = S_FIN;
        end else if (level == LEAF_LEVEL) begin
          state_next = S_LEAF;
        end else if (sts.dirty_fresh) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_SWEEP;
        end else begin
          state_next = S_ALLOC;
        end
      end
      S_SWEEP: begin
        cmd.sweep_we = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.sweep_last) state_next = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        level_next = level + 2'd1;
        state_next = S_CHECK;
      end
      S_LEAF: begin
        cmd.leaf_we  = 1'b1;
        res_sel_next = RES_DONE;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.res_load) out_valid_next = 1'b1;
  end

endmodule

// ===== hdl/ptw_dp.sv =====
// datapath: table store, frame pointer, bump allocator, registers, result
// depends on ptw_pkg; driven by ptw_ctrl commands
module ptw_dp import ptw_pkg::*; #(
  parameter int TABLE_FRAMES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptw_cmd_t             cmd,
  output ptw_sts_t             sts,
  input  logic                 kind,
  input  logic [VA_W-1:0]      virtual_address,
  input  logic [PA_W-1:0]      physical_address,
  input  logic [FLAG_W-1:0]    page_flags,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PA_W-1:0]      cfg_data,
  output logic [VA_W-1:0]      result_address,
  output logic [STATUS_W-1:0]  status
);

  localparam int FW    = $clog2(TABLE_FRAMES);
  localparam int NFW   = $clog2(TABLE_FRAMES + 1);
  localparam int DEPTH = TABLE_FRAMES * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PG_W  = PA_W - PAGE_SHIFT;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;

  logic [PA_W-1:0]   table_base, frame_mask;
  logic [FLAG_W-1:0] entry_flags;

  logic              kind_q;
  logic [VA_W-1:0]   va_q;
  logic [PA_W-1:0]   pa_q;
  logic [FLAG_W-1:0] flags_q;

  logic [FW-1:0]      frame;
  logic [NFW-1:0]     next_free;
  logic [FW-1:0]      fresh;
  logic [2**FW-1:0]   dirty, dirty_next;
  logic [AW-1:0]      cnt;

  logic [SLOT_W-1:0]  slot;
  logic [PA_W-1:0]    masked, diff;
  logic [PG_W-1:0]    diff_pg, new_pg;
  logic [ENTRY_W-1:0] new_entry, leaf_entry;
  logic [1:0]         need;
  logic [NFW:0]       demand;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_base  <= '0;
      frame_mask  <= FRAME_MASK_RST;
      entry_flags <= ENTRY_FLAGS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TABLE_BASE:  table_base  <= cfg_data;
        CFG_FRAME_MASK:  frame_mask  <= cfg_data;
        CFG_ENTRY_FLAGS: entry_flags <= cfg_data[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_q  <= kind;
      va_q    <= virtual_address;
      pa_q    <= physical_address;
      flags_q <= page_flags;
    end
  end

  // entry decode: masked address relative to the store base, in frames
  assign masked  = rdata[PA_W-1:0] & frame_mask;
  assign diff    = masked - table_base;
  assign diff_pg = diff[PA_W-1:PAGE_SHIFT];

  assign fresh  = next_free[FW-1:0];
  assign new_pg = table_base[PA_W-1:PAGE_SHIFT] + PG_W'(next_free);
  assign new_entry = {{(ENTRY_W-PA_W){1'b0}},
                      {new_pg, table_base[PAGE_SHIFT-1:0]} | {{PG_W{1'b0}}, entry_flags}};
  assign leaf_entry = {{(ENTRY_W-PA_W){1'b0}}, pa_q | {{PG_W{1'b0}}, flags_q}};

  assign need   = LEAF_LEVEL - cmd.level;
  assign demand = (NFW+1)'(next_free) + (NFW+1)'(need);

  assign slot = slot_of(va_q, cmd.level);

  always_comb begin
    sts.follow_ok   = rdata[0] && (diff_pg < PG_W'(TABLE_FRAMES));
    sts.room_ok     = demand <= (NFW+1)'(TABLE_FRAMES);
    sts.dirty_fresh = dirty[fresh];
    sts.sweep_last  = cnt[SLOT_W-1:0] == {SLOT_W{1'b1}};
    sts.clr_last    = cnt == AW'(DEPTH - 1);
    sts.is_map      = kind_q == KIND_MAP;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) frame <= '0;
    else if (cmd.take) frame <= diff_pg[FW-1:0];
    else if (cmd.alloc) frame <= fresh;
  end

  // frames holding written entries; a fresh frame is all zero once swept
  always_comb begin
    dirty_next = dirty;
    if (cmd.alloc) begin
      dirty_next[fresh] = 1'b0;
      dirty_next[frame] = 1'b1;
    end
    if (cmd.leaf_we) dirty_next[frame] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= NFW'(1);
      dirty     <= '0;
      cnt       <= '0;
    end else begin
      if (cmd.alloc) next_free <= next_free + NFW'(1);
      dirty <= dirty_next;
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + AW'(1);
    end
  end

  // single port: one write or one read per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {frame, slot};
    mem_wdata = '0;
    if (cmd.clr_we) begin
      mem_we   = 1'b1;
      mem_addr = cnt;
    end else if (cmd.sweep_we) begin
      mem_we   = 1'b1;
      mem_addr = {fresh, cnt[SLOT_W-1:0]};
    end else if (cmd.alloc) begin
      mem_we    = 1'b1;
      mem_wdata = new_entry;
    end else if (cmd.leaf_we) begin
      mem_we    = 1'b1;
      mem_wdata = leaf_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    else if (cmd.rd) rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_HIT: begin
          result_address <= {{(VA_W-PA_W){1'b0}}, masked};
          status         <= ST_DONE;
        end
        RES_MISS: begin
          result_address <= va_q;
          status         <= ST_MISS;
        end
        RES_FULL: begin
          result_address <= '0;
          status         <= ST_FULL;
        end
        default: begin
          result_address <= '0;
          status         <= ST_DONE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/four_level_page_table_walker_top.sv =====
// four-level page table walker, one request at a time over a single-port table store
// lookup: each level takes a read state then a decode state, down through all levels on a hit
// map: walk to the first gap; per missing level sweep if dirty, allocate; write the leaf
// latency is set by the reads and sweeps on the one memory port; next request after result
// reset: synchronous, then a clearing pass over the whole table store before the first request
// depends on ptw_pkg, ptw_if, ptw_ctrl, ptw_dp and assert_macros.svh
`include "assert_macros.svh"
module four_level_page_table_walker_top import ptw_pkg::*; #(
  parameter int TABLE_FRAMES = 64
) (
  input logic         clk,
  input logic         rst,
  ptw_req_if.sink     req,
  ptw_rsp_if.source   rsp,
  ptw_cfg_if.sink     cfg
);

  ptw_cmd_t   cmd;
  ptw_sts_t   sts;
  logic [4:0] port_ops;

  assign cfg.ready = 1'b1;
  assign port_ops  = {cmd.rd, cmd.clr_we, cmd.sweep_we, cmd.alloc, cmd.leaf_we};

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ptw_dp #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .kind             (req.kind),
    .virtual_address  (req.virtual_address),
    .physical_address (req.physical_address),
    .page_flags       (req.page_flags),
    .cfg_we           (cfg.valid && cfg.ready),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .result_address   (rsp.result_address),
    .status           (rsp.status)
  );

  `ASSERT_NEXT(a_one_walk, clk, rst, req.valid && req.ready, !req.ready, "request taken in walk")
  `ASSERT_ALWAYS(a_one_port, clk, rst, $onehot0(port_ops), "table store port conflict")
  `ASSERT_IMPLY(a_alloc_room, clk, rst, cmd.alloc, sts.room_ok, "allocation past the last frame")
  `ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.res_load, !rsp.valid || rsp.ready, "result lost")

endmodule

// ===== bench/four_level_page_table_walker_top_test.sv =====
`timescale 1ns / 100ps
// testbench for four_level_page_table_walker_top: directed and random lookups and maps,
// each result checked against a behavioral walk over a private copy of the table store
// depends on ptw_pkg, the ptw_if channel interfaces and the walker rtl
module four_level_page_table_walker_top_test;
  import ptw_pkg::*;

  localparam int TABLE_FRAMES = 64;
  localparam int STORE_DEPTH  = TABLE_FRAMES * SLOTS;
  localparam int NO_TABLE     = -1;

  typedef struct {
    logic              kind;
    logic [VA_W-1:0]   va;
    logic [PA_W-1:0]   pa;
    logic [FLAG_W-1:0] flags;
  } walk_req_t;

  typedef struct {
    logic [VA_W-1:0] addr;
    status_t         status;
  } walk_res_t;

  logic clk = 1'b0;
  logic rst;

  ptw_req_if req_ch();
  ptw_rsp_if rsp_ch();
  ptw_cfg_if cfg_ch();

  four_level_page_table_walker_top #(.TABLE_FRAMES(TABLE_FRAMES)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the table store, allocator and registers
  logic [ENTRY_W-1:0] pt_image [STORE_DEPTH];
  int unsigned        next_frame;
  logic [PA_W-1:0]    base_reg;
  logic [PA_W-1:0]    mask_reg;
  logic [FLAG_W-1:0]  eflags_reg;

  walk_res_t       walk_results_q[$];
  logic [VA_W-1:0] mapped_vas[$];
  int unsigned     lvl_pool [3][2];

  int  fail_count = 0;
  int  n_lookup = 0, n_hit = 0, n_miss = 0, n_map = 0, n_full = 0, n_settings = 0;
  bit  idle_on = 1'b0;
  bit  rsp_block = 1'b0;
  int  rsp_stall = 0;
  int  hold_len = 0;
  event hold_go;

  function automatic int unsigned slot_at(logic [VA_W-1:0] va, int lvl);
    return int'((va >> (SHIFT_L0 - SLOT_W * lvl)) & 64'h1FF);
  endfunction

  // frame an entry leads to, or NO_TABLE when absent or outside the store
  function automatic int table_of(logic [ENTRY_W-1:0] e);
    logic [PA_W-1:0] off;
    off = (e[PA_W-1:0] & mask_reg) - base_reg;
    if (!e[0] || off[PA_W-1:PAGE_SHIFT] >= TABLE_FRAMES) return NO_TABLE;
    return int'(off[PA_W-1:PAGE_SHIFT]);
  endfunction

  function automatic walk_res_t predict_walk(walk_req_t r);
    walk_res_t       res;
    int              nxt;
    int unsigned     fr, lvl, found, fresh, idx;
    logic [PA_W-1:0] taddr;
    fr = 0;
    res.addr = '0;
    res.status = ST_DONE;
    if (r.kind == KIND_LOOKUP) begin
      for (lvl = 0; lvl < 3; lvl++) begin
        nxt = table_of(pt_image[fr * SLOTS + slot_at(r.va, lvl)]);
        if (nxt == NO_TABLE) begin
          res.addr = r.va;
          res.status = ST_MISS;
          return res;
        end
        fr = nxt;
      end
      res.addr = VA_W'(pt_image[fr * SLOTS + slot_at(r.va, 3)][PA_W-1:0] & mask_reg);
      return res;
    end
    found = 0;
    while (found < 3) begin
      nxt = table_of(pt_image[fr * SLOTS + slot_at(r.va, found)]);
      if (nxt == NO_TABLE) break;
      fr = nxt;
      found++;
    end
    // refuse before touching anything when the missing tables do not fit
    if (next_frame + (3 - found) > TABLE_FRAMES) begin
      res.status = ST_FULL;
      return res;
    end
    for (lvl = found; lvl < 3; lvl++) begin
      fresh = next_frame;
      next_frame++;
      taddr = base_reg + (PA_W'(fresh) << PAGE_SHIFT);
      for (idx = 0; idx < SLOTS; idx++) pt_image[fresh * SLOTS + idx] = '0;
      pt_image[fr * SLOTS + slot_at(r.va, lvl)] = ENTRY_W'(taddr | PA_W'(eflags_reg));
      fr = fresh;
    end
    pt_image[fr * SLOTS + slot_at(r.va, 3)] = ENTRY_W'(r.pa | PA_W'(r.flags));
    return res;
  endfunction

  function automatic logic [VA_W-1:0] compose_va(int unsigned i0, int unsigned i1,
                                                 int unsigned i2, int unsigned i3);
    logic [VA_W-1:0] va;
    va = {$urandom, $urandom};
    va[SHIFT_L0 +: SLOT_W] = SLOT_W'(i0);
    va[SHIFT_L1 +: SLOT_W] = SLOT_W'(i1);
    va[SHIFT_L2 +: SLOT_W] = SLOT_W'(i2);
    va[SHIFT_L3 +: SLOT_W] = SLOT_W'(i3);
    return va;
  endfunction

  function automatic int unsigned pick_slot();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return SLOTS - 1;
      default: return $urandom_range(0, SLOTS - 1);
    endcase
  endfunction

  function automatic logic [VA_W-1:0] pool_va();
    return compose_va(lvl_pool[0][$urandom_range(0, 1)], lvl_pool[1][$urandom_range(0, 1)],
                      lvl_pool[2][$urandom_range(0, 1)], $urandom_range(0, SLOTS - 1));
  endfunction

  // mostly maps and lookups on a few shared paths, some anywhere at all
  function automatic walk_req_t random_walk();
    walk_req_t   r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r.pa = PA_W'({$urandom, $urandom});
    r.flags = FLAG_W'($urandom);
    r.kind = KIND_LOOKUP;
    if (sel < 10) begin
      r.kind = ($urandom_range(0, 9) == 0) ? KIND_MAP : KIND_LOOKUP;
      r.va = {$urandom, $urandom};
    end else if (sel < 45) begin
      r.kind = KIND_MAP;
      r.va = pool_va();
    end else if (sel < 80 && mapped_vas.size() != 0) begin
      r.va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
      r.va[VA_W-1:48] = 16'($urandom);
      r.va[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
    end else begin
      r.va = pool_va();
    end
    return r;
  endfunction

  task automatic send_walk(logic kind, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                           logic [FLAG_W-1:0] flags);
    walk_req_t r;
    walk_res_t res;
    int        gap;
    r.kind = kind;
    r.va = va;
    r.pa = pa;
    r.flags = flags;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.virtual_address <= va;
    req_ch.physical_address <= pa;
    req_ch.page_flags <= flags;
    do @(posedge clk); while (!req_ch.ready);
    res = predict_walk(r);
    walk_results_q.push_back(res);
    if (kind == KIND_MAP) begin
      n_map++;
      if (res.status == ST_FULL) n_full++;
      else begin
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 64) void'(mapped_vas.pop_front());
      end
    end else begin
      n_lookup++;
      if (res.status == ST_MISS) n_miss++;
      else n_hit++;
    end
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [PA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_TABLE_BASE: base_reg = val;
      CFG_FRAME_MASK: mask_reg = val;
      default:        eflags_reg = val[FLAG_W-1:0];
    endcase
    n_settings++;
    @(posedge clk);
  endtask

  task automatic new_pools();
    int lvl;
    for (lvl = 0; lvl < 3; lvl++) begin
      lvl_pool[lvl][0] = pick_slot();
      lvl_pool[lvl][1] = pick_slot();
    end
  endtask

  task automatic run_random(int count);
    walk_req_t r;
    int        i;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_on <= ($urandom_range(0, 2) != 0);
      r = random_walk();
      send_walk(r.kind, r.va, r.pa, r.flags);
    end
  endtask

  task automatic test_directed();
    write_reg(CFG_TABLE_BASE, '0);
    write_reg(CFG_FRAME_MASK, FRAME_MASK_RST);
    write_reg(CFG_ENTRY_FLAGS, PA_W'(ENTRY_FLAGS_RST));
    // empty store: every lookup misses at the root
    send_walk(KIND_LOOKUP, '1, '0, '0);
    send_walk(KIND_LOOKUP, '0, '1, '1);
    send_walk(KIND_MAP, '0, '0, '0);
    // leaf of zero still counts as a hit
    send_walk(KIND_LOOKUP, '0, '1, '1);
    send_walk(KIND_MAP, compose_va(0, 0, 0, SLOTS - 1), '1, '1);
    send_walk(KIND_LOOKUP, compose_va(0, 0, 0, SLOTS - 1), '0, '0);
    send_walk(KIND_LOOKUP, compose_va(0, 0, 0, 5), '0, '0);
    send_walk(KIND_MAP, '1, PA_W'({$urandom, $urandom}), FLAG_W'($urandom));
    // bits 63:48 take no part in the walk
    send_walk(KIND_LOOKUP, {16'h0000, 48'hFFFF_FFFF_FFFF}, '0, '0);
    send_walk(KIND_MAP, compose_va(SLOTS - 1, 0, 0, 0), PA_W'({$urandom, $urandom}), '0);
    send_walk(KIND_LOOKUP, compose_va(SLOTS - 1, SLOTS - 1, 0, 0), '0, '0);
    send_walk(KIND_LOOKUP, compose_va(SLOTS - 1, 7, 0, 0), '0, '0);
    send_walk(KIND_LOOKUP, compose_va(3, 0, 0, 0), '0, '0);
    // remap of an existing leaf allocates nothing
    send_walk(KIND_MAP, '1, '0, '0);
    send_walk(KIND_LOOKUP, '1, '0, '0);
    wait_all_results();
  endtask

  task automatic test_random();
    new_pools();
    run_random(350);
    wait_all_results();
  endtask

  task automatic test_back_pressure();
    new_pools();
    hold_len = 200;
    -> hold_go;
    run_random(12);
    wait_all_results();
    run_random(20);
    wait_all_results();
  endtask

  task automatic test_frame_mask();
    write_reg(CFG_FRAME_MASK, '1);
    run_random(60);
    wait_all_results();
    // every present entry now leads back to the root
    write_reg(CFG_FRAME_MASK, '0);
    send_walk(KIND_LOOKUP, '1, '0, '0);
    run_random(25);
    wait_all_results();
    write_reg(CFG_FRAME_MASK, FRAME_MASK_RST);
    run_random(20);
    wait_all_results();
  endtask

  task automatic test_entry_flags();
    write_reg(CFG_ENTRY_FLAGS, PA_W'(12'hFFF));
    new_pools();
    run_random(40);
    wait_all_results();
    // new entries lack the present bit, so the next map allocates again
    write_reg(CFG_ENTRY_FLAGS, '0);
    repeat (2) send_walk(KIND_MAP, compose_va(9, 9, 9, $urandom_range(0, SLOTS - 1)),
                         PA_W'({$urandom, $urandom}), FLAG_W'($urandom));
    send_walk(KIND_LOOKUP, compose_va(9, 9, 9, 0), '0, '0);
    wait_all_results();
    write_reg(CFG_ENTRY_FLAGS, PA_W'(ENTRY_FLAGS_RST));
    run_random(20);
    wait_all_results();
  endtask

  task automatic test_region_base();
    // old entries now point outside the store
    write_reg(CFG_TABLE_BASE, 52'h0_0001_0000_0000);
    send_walk(KIND_LOOKUP, '0, '0, '0);
    send_walk(KIND_MAP, '0, PA_W'({$urandom, $urandom}), FLAG_W'($urandom));
    send_walk(KIND_LOOKUP, '0, '0, '0);
    new_pools();
    run_random(40);
    wait_all_results();
    write_reg(CFG_TABLE_BASE, '1);
    run_random(30);
    wait_all_results();
    write_reg(CFG_TABLE_BASE, PA_W'({$urandom, $urandom}));
    run_random(20);
    wait_all_results();
    write_reg(CFG_TABLE_BASE, '0);
    run_random(20);
    wait_all_results();
  endtask

  task automatic test_store_full();
    int i;
    write_reg(CFG_ENTRY_FLAGS, '0);
    for (i = 0; i < 40 && next_frame + 1 < TABLE_FRAMES; i++)
      send_walk(KIND_MAP, {$urandom, $urandom}, PA_W'({$urandom, $urandom}), FLAG_W'($urandom));
    repeat (4) send_walk(KIND_MAP, {$urandom, $urandom}, '1, '1);
    wait_all_results();
    write_reg(CFG_ENTRY_FLAGS, PA_W'(ENTRY_FLAGS_RST));
    run_random(180);
    wait_all_results();
  endtask

  // result side: random stalls per result, plus a long hold on demand
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = 0;
    end else if (rsp_block) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      rsp_stall = idle_on ? $urandom_range(0, 4) : 0;
      rsp_ch.ready <= (rsp_stall == 0);
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= (rsp_stall == 0);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(hold_go);
      rsp_block <= 1'b1;
      repeat (hold_len) @(posedge clk);
      rsp_block <= 1'b0;
    end
  end

  always @(posedge clk) begin
    walk_res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (walk_results_q.size() == 0) begin
        $display("%0t: result with no request pending: addr %h status %0d", $time,
                 rsp_ch.result_address, rsp_ch.status);
        fail_count++;
      end else begin
        want = walk_results_q.pop_front();
        if (rsp_ch.result_address !== want.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, want.addr,
                   rsp_ch.result_address);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int i;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_LOOKUP;
    req_ch.virtual_address <= '0;
    req_ch.physical_address <= '0;
    req_ch.page_flags <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TABLE_BASE;
    cfg_ch.data <= '0;
    for (i = 0; i < STORE_DEPTH; i++) pt_image[i] = '0;
    next_frame = 1;
    base_reg = '0;
    mask_reg = FRAME_MASK_RST;
    eflags_reg = ENTRY_FLAGS_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random();
    test_back_pressure();
    test_frame_mask();
    test_entry_flags();
    test_region_base();
    test_store_full();
    repeat (20) @(posedge clk);

    $display("walked %0d lookups (%0d hits, %0d misses) and %0d maps (%0d refused, store full)",
             n_lookup, n_hit, n_miss, n_map, n_full);
    $display("over %0d register writes, %0d of %0d table frames in use at the end",
             n_settings, next_frame, TABLE_FRAMES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
